// File: rtl/assert_macros.svh
// assertion macros shared by the frame allocator rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bfa_pkg.sv
// shared constants, codes and control types of the bitmap frame allocator
// no dependencies; imported by bfa_ctrl, bfa_dpath and bitmap_frame_allocator
package bfa_pkg;

    // geometry of the managed memory
    localparam int unsigned MAX_FRAMES  = 4096;
    localparam int unsigned FRAME_BYTES = 4096;
    localparam int unsigned FRAME_SHIFT = $clog2(FRAME_BYTES);
    localparam int unsigned WORD_BITS   = 32;
    localparam int unsigned BIT_W       = $clog2(WORD_BITS);
    localparam int unsigned MAP_WORDS   = MAX_FRAMES / WORD_BITS;
    localparam int unsigned WORD_AW     = $clog2(MAP_WORDS);
    localparam int unsigned IDX_W       = $clog2(MAX_FRAMES);
    localparam int unsigned FRAME_W     = 13;
    localparam int unsigned POP_W       = BIT_W + 1;

    // beat widths
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned S_DATA_W = 64;
    localparam int unsigned M_DATA_W = 48;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [FRAME_W-1:0]   t_frame;
    typedef logic [1:0]           t_kind;
    typedef logic [1:0]           t_status;
    typedef logic                 t_cfg_idx;

    localparam t_word ALL_ONES = '1;

    // item kinds
    localparam t_kind KIND_ALLOC   = 2'd0;
    localparam t_kind KIND_FREE    = 2'd1;
    localparam t_kind KIND_RELEASE = 2'd2;
    localparam t_kind KIND_RESERVE = 2'd3;

    // result status codes
    localparam t_status ST_DONE      = 2'd0;
    localparam t_status ST_NO_FREE   = 2'd1;
    localparam t_status ST_REJECTED  = 2'd2;
    localparam t_status ST_WAS_FREE  = 2'd3;

    // configuration register indexes
    localparam t_cfg_idx CFG_TOTAL_FRAMES = 1'b0;
    localparam t_cfg_idx CFG_FIRST_USABLE = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic prep;
        logic pass1;
        logic scan;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic more_pass;
        logic scan_end;
        logic out_free;
    } t_stat;

endpackage

// File: rtl/bfa_ctrl.sv
// sequencing state machine of the bitmap frame allocator
// depends on bfa_pkg and assert_macros.svh; drives the datapath through t_cmd
`include "assert_macros.svh"

module bfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  bfa_pkg::t_stat i_stat,
    output bfa_pkg::t_cmd  o_cmd
);
    import bfa_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_PASS1 = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.load  = accept;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_CHK;
            end
            S_CHK: begin
                if (!i_stat.empty) begin
                    n_state = S_SCAN;
                end else if (i_stat.more_pass) begin
                    n_state = S_PASS1;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_end) begin
                    n_state = i_stat.more_pass ? S_PASS1 : S_FIN;
                end
            end
            S_PASS1: begin
                o_cmd.pass1 = 1'b1;
                n_state     = S_CHK;
            end
            S_FIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ASSERT_NEXT(a_accept_to_prep, i_clk, i_rst_n, accept, r_state == S_PREP, "accepted beat did not start preparation")
    `ASSERT_IMPLIES(a_emit_only_done, i_clk, i_rst_n, o_cmd.emit, r_state == S_DONE && i_stat.out_free, "result emitted outside done state")

endmodule

// File: rtl/bfa_dpath.sv
// datapath of the bitmap frame allocator: used-bit map, counters, scan pipe
// depends on bfa_pkg and assert_macros.svh; controlled by bfa_ctrl
`include "assert_macros.svh"

module bfa_dpath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  bfa_pkg::t_cfg_idx          i_cfg_idx,
    input  bfa_pkg::t_frame            i_cfg_wdata,
    input  logic [bfa_pkg::S_DATA_W-1:0] i_s_tdata,
    input  bfa_pkg::t_kind             i_s_tuser,
    input  logic                       i_m_tready,
    output logic                       o_m_tvalid,
    output logic [bfa_pkg::M_DATA_W-1:0] o_m_tdata,
    output bfa_pkg::t_status           o_m_tuser,
    input  bfa_pkg::t_cmd              i_cmd,
    output bfa_pkg::t_stat             o_stat
);
    import bfa_pkg::*;

    // configuration and item registers
    t_frame                r_total;
    t_frame                r_first;
    t_kind                 r_kind;
    logic [ADDR_W-1:0]     r_addr;
    logic [ADDR_W-1:0]     r_len;

    // allocator state
    t_frame                r_count;
    t_frame                r_hint;
    t_word                 r_mem [MAP_WORDS];
    logic [MAP_WORDS-1:0]  r_vld;

    // per-item control
    t_frame                r_b;
    t_frame                r_e;
    logic                  r_pass1;
    logic                  r_found;
    t_status               r_status;
    logic [ADDR_W-1:0]     r_fa;

    // scan pipe
    logic [WORD_AW-1:0]    r_rd_word;
    logic                  r_issue;
    logic                  r_dv;
    logic [WORD_AW-1:0]    r_dw;
    t_word                 r_rdata;
    logic                  r_rvld;
    logic [POP_W-1:0]      r_pop;
    logic                  r_pend;

    // output register
    logic                  r_ovalid;
    logic [M_DATA_W-1:0]   r_odata;
    t_status               r_ouser;

    // combinational
    t_frame                eff_total;
    logic [ADDR_W-FRAME_SHIFT-1:0] f_free;
    logic                  free_bad;
    logic [ADDR_W+1:0]     rel_sum;
    logic [ADDR_W-FRAME_SHIFT+1:0] rel_e;
    logic                  rel_ok;
    t_frame                rel_b;
    t_frame                rel_ec;
    logic                  alloc_ok;
    t_frame                n_b;
    t_frame                n_e;
    t_frame                e_m1;
    logic [WORD_AW-1:0]    last_word;
    t_word                 word;
    t_word                 lo_mask;
    t_word                 hi_mask;
    t_word                 mask;
    t_word                 free_bits;
    t_word                 used_bits;
    logic                  hit;
    logic [BIT_W-1:0]      idx;
    logic [IDX_W-1:0]      alloc_f;
    logic                  alloc_hit;
    logic                  free_hit;
    logic                  free_miss;
    logic                  mem_we;
    t_word                 mem_wdata;
    logic                  scan_end;
    logic                  issue;
    t_frame                n_count;

    // effective total and item checks
    assign eff_total = (r_total > t_frame'(MAX_FRAMES)) ? t_frame'(MAX_FRAMES) : r_total;
    assign f_free    = r_addr[ADDR_W-1:FRAME_SHIFT];
    assign free_bad  = (r_addr == '0)
                    || (f_free < (ADDR_W-FRAME_SHIFT)'(r_first))
                    || (f_free >= (ADDR_W-FRAME_SHIFT)'(eff_total));
    assign rel_sum   = {2'b00, r_addr} + {2'b00, r_len} + (ADDR_W+2)'(FRAME_BYTES - 1);
    assign rel_e     = rel_sum[ADDR_W+1:FRAME_SHIFT];
    assign rel_ok    = (r_len != '0) && (eff_total != '0)
                    && ({2'b00, f_free} < rel_e)
                    && (f_free < (ADDR_W-FRAME_SHIFT)'(eff_total));
    assign rel_b     = (f_free[FRAME_W-1:0] < r_first) ? r_first : f_free[FRAME_W-1:0];
    assign rel_ec    = (rel_e > (ADDR_W-FRAME_SHIFT+2)'(eff_total)) ? eff_total
                                                                    : rel_e[FRAME_W-1:0];
    assign alloc_ok  = (r_count != '0) && (eff_total != '0);

    // frame range of the next pass
    always_comb begin
        n_b = '0;
        n_e = '0;
        if (i_cmd.pass1) begin
            n_b = r_first;
            n_e = (r_hint < eff_total) ? r_hint : eff_total;
        end else begin
            case (r_kind)
                KIND_ALLOC: begin
                    if (alloc_ok) begin
                        n_b = r_hint;
                        n_e = eff_total;
                    end
                end
                KIND_FREE: begin
                    if (!free_bad) begin
                        n_b = f_free[FRAME_W-1:0];
                        n_e = f_free[FRAME_W-1:0] + t_frame'(1);
                    end
                end
                KIND_RELEASE: begin
                    if (rel_ok) begin
                        n_b = rel_b;
                        n_e = rel_ec;
                    end
                end
                default: begin
                    n_b = '0;
                    n_e = '0;
                end
            endcase
        end
    end

    // word masks and search of the evaluated word
    assign e_m1      = r_e - t_frame'(1);
    assign last_word = e_m1[BIT_W +: WORD_AW];
    assign word      = r_rvld ? r_rdata : ALL_ONES;
    assign lo_mask   = (r_dw == r_b[BIT_W +: WORD_AW]) ? (ALL_ONES << r_b[BIT_W-1:0]) : ALL_ONES;
    assign hi_mask   = (r_dw == last_word) ? ~((ALL_ONES << 1) << e_m1[BIT_W-1:0]) : ALL_ONES;
    assign mask      = lo_mask & hi_mask;
    assign free_bits = ~word & mask;
    assign used_bits = word & mask;
    assign hit       = |free_bits;

    // lowest free bit
    always_comb begin
        idx = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (free_bits[j]) begin
                idx = BIT_W'(j);
            end
        end
    end

    assign alloc_f   = {r_dw, idx};
    assign alloc_hit = r_dv && (r_kind == KIND_ALLOC) && hit;
    assign free_hit  = r_dv && (r_kind == KIND_FREE) && (|used_bits);
    assign free_miss = r_dv && (r_kind == KIND_FREE) && !(|used_bits);
    assign scan_end  = r_dv && (alloc_hit || (r_dw == last_word));
    assign issue     = i_cmd.scan && r_issue && !scan_end;

    // map write-back
    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = word & ~mask;
        case (r_kind)
            KIND_ALLOC: begin
                mem_we    = alloc_hit;
                mem_wdata = word | (t_word'(1) << idx);
            end
            KIND_FREE: begin
                mem_we = free_hit;
            end
            KIND_RELEASE: begin
                mem_we = r_dv;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // free count update
    always_comb begin
        n_count = r_count;
        if (i_cmd.prep && (r_kind == KIND_RESERVE)) begin
            n_count = '0;
        end else if (r_pend) begin
            n_count = r_count + FRAME_W'(r_pop);
        end else if (alloc_hit) begin
            n_count = r_count - t_frame'(1);
        end else if (free_hit) begin
            n_count = r_count + t_frame'(1);
        end
    end

    // status to controller
    assign o_stat.empty     = (r_b >= r_e);
    assign o_stat.more_pass = (r_kind == KIND_ALLOC) && !r_pass1 && !r_found && !alloc_hit;
    assign o_stat.scan_end  = scan_end;
    assign o_stat.out_free  = !r_ovalid || i_m_tready;

    // map memory and read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_dw] <= mem_wdata;
        end
        if (issue) begin
            r_rdata <= r_mem[r_rd_word];
            r_rvld  <= r_vld[r_rd_word];
        end
    end

    // item payload and per-item working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_s_tuser;
            r_addr <= i_s_tdata[ADDR_W-1:0];
            r_len  <= i_s_tdata[S_DATA_W-1:ADDR_W];
        end
        if (i_cmd.prep || i_cmd.pass1) begin
            r_b       <= n_b;
            r_e       <= n_e;
            r_rd_word <= n_b[BIT_W +: WORD_AW];
        end else if (issue) begin
            r_rd_word <= r_rd_word + WORD_AW'(1);
        end
        if (issue) begin
            r_dw <= r_rd_word;
        end
        r_pop <= POP_W'($countones(used_bits));
        if (i_cmd.prep) begin
            r_fa <= '0;
        end else if (alloc_hit) begin
            r_fa <= ADDR_W'({alloc_f, {FRAME_SHIFT{1'b0}}});
        end
        if (i_cmd.emit) begin
            r_odata <= M_DATA_W'({r_count, r_fa});
            r_ouser <= r_status;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= '0;
            r_first  <= t_frame'(256);
            r_count  <= '0;
            r_hint   <= t_frame'(256);
            r_vld    <= '0;
            r_pass1  <= 1'b0;
            r_found  <= 1'b0;
            r_status <= ST_DONE;
            r_issue  <= 1'b0;
            r_dv     <= 1'b0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TOTAL_FRAMES: r_total <= i_cfg_wdata;
                    CFG_FIRST_USABLE: r_first <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end

            r_count <= n_count;

            // search hint
            if (i_cmd.prep && (r_kind == KIND_RESERVE)) begin
                r_hint <= r_first;
            end else if (alloc_hit) begin
                r_hint <= FRAME_W'(alloc_f);
            end else if (free_hit && (r_b < r_hint)) begin
                r_hint <= r_b;
            end

            // valid bits of map words
            if (i_cmd.prep && (r_kind == KIND_RESERVE)) begin
                r_vld <= '0;
            end else if (mem_we) begin
                r_vld[r_dw] <= 1'b1;
            end

            // per-item flags and status
            if (i_cmd.prep) begin
                r_found  <= 1'b0;
                r_pass1  <= !((r_kind == KIND_ALLOC) && alloc_ok);
                case (r_kind)
                    KIND_ALLOC: r_status <= ST_NO_FREE;
                    KIND_FREE:  r_status <= free_bad ? ST_REJECTED : ST_DONE;
                    default:    r_status <= ST_DONE;
                endcase
            end else begin
                if (i_cmd.pass1) begin
                    r_pass1 <= 1'b1;
                end
                if (alloc_hit) begin
                    r_found  <= 1'b1;
                    r_status <= ST_DONE;
                end else if (free_miss) begin
                    r_status <= ST_WAS_FREE;
                end
            end

            // scan pipe control
            if (i_cmd.prep || i_cmd.pass1) begin
                r_issue <= 1'b1;
            end else if (issue && (r_rd_word == last_word)) begin
                r_issue <= 1'b0;
            end else if (scan_end) begin
                r_issue <= 1'b0;
            end
            r_dv   <= issue;
            r_pend <= r_dv && (r_kind == KIND_RELEASE);

            // output register
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= t_frame'(MAX_FRAMES), "free count above frame total")
    `ASSERT_IMPLIES(a_data_from_scan, i_clk, i_rst_n, r_dv, $past(i_cmd.scan), "map word evaluated outside a scan")
    `ASSERT_NEXT(a_hit_ends_scan, i_clk, i_rst_n, alloc_hit, !r_dv && r_found, "scan kept running after an allocation")

endmodule

// File: rtl/bitmap_frame_allocator.sv
// Bitmap page-frame allocator, top level: one used bit per 4 KiB frame, a free
// count and a next-fit hint. Input beat: tuser = kind, tdata = address and
// region length. Output beat: tdata = frame address and free count, tuser =
// status. Configuration: i_cfg_we/i_cfg_idx/i_cfg_wdata write total_frames (0)
// and first_usable_frame (1); write only while the block is idle.
// One result beat per input beat, in order. One item is processed at a time.
// Release and allocate read one 32-bit map word per cycle through the single
// map read port; an allocate may scan the 4096-frame map in two passes.
// Reset marks every frame used, zeroes the free count, loads total_frames 0 and
// first_usable_frame and hint 256; reset is synchronous and needs no pass over the map.
// A held output beat does not block acceptance of the next item; that item
// runs to completion and then waits until the held beat is taken.
module bitmap_frame_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [12:0] i_cfg_wdata,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // address[31:0], region_length[63:32]
    input  logic [1:0]  i_s_axis_tuser,   // kind[1:0]
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // frame_address[31:0], free_count[44:32], zero pad
    output logic [1:0]  o_m_axis_tuser    // status[1:0]
);
    import bfa_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    bfa_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (stat),
        .o_cmd           (cmd)
    );

    bfa_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_tuser   (i_s_axis_tuser),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tvalid  (o_m_axis_tvalid),
        .o_m_tdata   (o_m_axis_tdata),
        .o_m_tuser   (o_m_axis_tuser),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule
